// File: hw/rtl/salc_pkg.sv
`timescale 1ns / 1ps
// shared constants and codes of the set-associative lru cache directory
// no dependencies

package salc_pkg;

   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAYS     = 8;

   localparam int CMD_W     = 2;
   localparam int ADDR_W    = 64;
   localparam int OUTCOME_W = 2;
   localparam int CNT_W     = 32;
   localparam int TAG_W     = 62;
   localparam int STAMP_W   = 64;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int SET_CFG_W  = 3;
   localparam int OFF_CFG_W  = 6;
   localparam int WAY_CFG_W  = 4;

   localparam int MAX_OFFSET_BITS = 32;

   // access kinds
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_IFETCH = 2'd3;

   // outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_HIT     = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_MISS    = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_EVICT   = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_IGNORED = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam logic [SET_CFG_W-1:0] SET_CFG_RESET = 3'd1;
   localparam logic [OFF_CFG_W-1:0] OFF_CFG_RESET = 6'd4;
   localparam logic [WAY_CFG_W-1:0] WAY_CFG_RESET = 4'd1;

   // one directory line
   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } way_type;

endpackage

// File: hw/rtl/salc_req_if.sv
`timescale 1ns / 1ps
// request channel: access kind and byte address
// depends on salc_pkg

interface salc_req_if import salc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ADDR_W-1:0] address;

   modport source(output valid, output cmd, output address, input ready);
   modport sink(input valid, input cmd, input address, output ready);
endinterface

// File: hw/rtl/salc_rsp_if.sv
`timescale 1ns / 1ps
// response channel: outcome and running totals
// depends on salc_pkg

interface salc_rsp_if import salc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic                 modify_extra_hit;
   logic [CNT_W-1:0]     hits_total;
   logic [CNT_W-1:0]     misses_total;
   logic [CNT_W-1:0]     evictions_total;

   modport source(output valid, output outcome, output modify_extra_hit,
                  output hits_total, output misses_total, output evictions_total,
                  input ready);
   modport sink(input valid, input outcome, input modify_extra_hit,
                input hits_total, input misses_total, input evictions_total,
                output ready);
endinterface

// File: hw/rtl/salc_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/set_assoc_lru_cache_model_core.sv
`timescale 1ns / 1ps
// set-associative lru cache directory, top level
// depends on salc_pkg, salc_req_if, salc_rsp_if, salc_ram

// usage
//   req_chan carries one trace access (cmd, address) per valid/ready request.
//   rsp_chan returns exactly one response per request, in order: outcome,
//   the modify extra-hit flag and the saturating hit/miss/eviction totals.
//   csr_* writes set_index_bits, offset_bits and ways_in_use; write only
//   while no request is in flight.
// timing
//   the set row is read from the directory ram in the accept cycle; in
//   ST_LOOK the ways in use are compared, the victim is picked, and on
//   commit the row is written back and the response register is loaded.
//   a new request is taken only after the current one has committed, set
//   by the read-modify-write of one row through the one-read, one-write ram.
// reset
//   after reset the ram is swept to all-zero, one set row a cycle, over
//   every set row; req_chan.ready stays low until the sweep ends.
// stall
//   the response sits in an output register; a new request is accepted
//   while it waits, and the next one holds its ram data until the response
//   slot frees, with no state written until then.

module set_assoc_lru_cache_model_core import salc_pkg::*; #(
   parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
   input  logic                  clock,
   input  logic                  reset,
   salc_req_if.sink              req_chan,
   salc_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int DEPTH    = 1 << MAX_SET_BITS;
   localparam int ROW_W    = MAX_WAYS * $bits(way_type);
   localparam int SB_W     = $clog2(MAX_SET_BITS + 1);
   localparam int EW_W     = $clog2(MAX_WAYS + 1);
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int LVL      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
   localparam int PAD      = 1 << LVL;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOOK  = 3'b100
   } state_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                input logic [1:0] n);
      logic [CNT_W:0] sum;
      sum = {1'b0, c} + (CNT_W + 1)'(n);
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

   // control state
   state_type state_ff, state_in;
   logic [MAX_SET_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic [SET_CFG_W-1:0] set_cfg_ff, set_cfg_in;
   logic [OFF_CFG_W-1:0] off_cfg_ff, off_cfg_in;
   logic [WAY_CFG_W-1:0] way_cfg_ff, way_cfg_in;
   logic [STAMP_W-1:0] clock_ff, clock_in;
   logic [CNT_W-1:0] hits_ff, hits_in, misses_ff, misses_in, evicts_ff, evicts_in;
   logic rsp_valid_ff, rsp_valid_in;

   // captured request
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic [TAG_W-1:0]        tag_ff, tag_in;
   logic [MAX_SET_BITS-1:0] set_ff, set_in;

   // response payload
   logic [OUTCOME_W-1:0] outcome_ff, outcome_in;
   logic                 extra_ff, extra_in;

   // clamped configuration
   logic [SB_W-1:0] s_cl;
   logic [5:0]      b_cl;
   logic [EW_W-1:0] e_cl;
   logic [6:0]      tag_shift;
   logic [ADDR_W-1:0] idx_full;

   // ram side
   logic                    ram_wr_en, ram_rd_en;
   logic [MAX_SET_BITS-1:0] ram_wr_addr;
   logic [ROW_W-1:0]        ram_wr_data, ram_rd_data;
   way_type [MAX_WAYS-1:0]  row_rd, row_new;

   // lookup
   logic [MAX_WAYS-1:0] way_en;
   logic                hit, have_free;
   logic [WAY_W-1:0]    hit_way, free_way, victim;
   logic [STAMP_W-1:0]  stamp_new;
   logic [STAMP_W-1:0]  nd_stamp [LVL+1][PAD];
   logic                nd_ok    [LVL+1][PAD];
   logic [WAY_W-1:0]    nd_idx   [LVL+1][PAD];
   logic                req_acc, commit, ignored;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc = req_chan.valid && req_chan.ready;
   assign commit  = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_chan.ready);
   assign ignored = (cmd_ff == CMD_IFETCH);

   // clamp the split and way count into their legal ranges
   always_comb begin
      if (set_cfg_ff == '0) begin
         s_cl = SB_W'(1);
      end else if (32'(set_cfg_ff) > MAX_SET_BITS) begin
         s_cl = SB_W'(MAX_SET_BITS);
      end else begin
         s_cl = SB_W'(set_cfg_ff);
      end
      if (off_cfg_ff == '0) begin
         b_cl = 6'd1;
      end else if (32'(off_cfg_ff) > MAX_OFFSET_BITS) begin
         b_cl = 6'(MAX_OFFSET_BITS);
      end else begin
         b_cl = off_cfg_ff;
      end
      if (way_cfg_ff == '0) begin
         e_cl = EW_W'(1);
      end else if (32'(way_cfg_ff) > MAX_WAYS) begin
         e_cl = EW_W'(MAX_WAYS);
      end else begin
         e_cl = EW_W'(way_cfg_ff);
      end
   end

   // address split at accept
   assign tag_shift = 7'(s_cl) + 7'(b_cl);
   assign idx_full  = req_chan.address >> b_cl;
   assign tag_in    = req_acc ? TAG_W'(req_chan.address >> tag_shift) : tag_ff;
   assign set_in    = req_acc ? (idx_full[MAX_SET_BITS-1:0] &
                                 ~({MAX_SET_BITS{1'b1}} << s_cl)) : set_ff;
   assign cmd_in    = req_acc ? req_chan.cmd : cmd_ff;

   assign row_rd    = ram_rd_data;
   assign stamp_new = clock_ff + STAMP_W'(1);

   // way search: first matching line, first free line
   always_comb begin
      hit       = 1'b0;
      have_free = 1'b0;
      hit_way   = '0;
      free_way  = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         way_en[i] = (EW_W'(i) < e_cl);
         if (way_en[i] && row_rd[i].valid && row_rd[i].tag == tag_ff) begin
            hit     = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (way_en[i] && !row_rd[i].valid) begin
            have_free = 1'b1;
            free_way  = WAY_W'(i);
         end
      end
   end

   // oldest-stamp tree, ties keep the lower way
   always_comb begin
      for (int l = 0; l <= LVL; l++) begin
         for (int j = 0; j < PAD; j++) begin
            nd_stamp[l][j] = '0;
            nd_ok[l][j]    = 1'b0;
            nd_idx[l][j]   = '0;
         end
      end
      for (int j = 0; j < MAX_WAYS; j++) begin
         nd_stamp[0][j] = row_rd[j].stamp;
         nd_ok[0][j]    = way_en[j];
         nd_idx[0][j]   = WAY_W'(j);
      end
      for (int l = 0; l < LVL; l++) begin
         for (int j = 0; j < PAD / 2; j++) begin
            if (j < (PAD >> (l + 1))) begin
               if (nd_ok[l][2*j] && (!nd_ok[l][2*j+1] ||
                   nd_stamp[l][2*j] <= nd_stamp[l][2*j+1])) begin
                  nd_stamp[l+1][j] = nd_stamp[l][2*j];
                  nd_ok[l+1][j]    = nd_ok[l][2*j];
                  nd_idx[l+1][j]   = nd_idx[l][2*j];
               end else begin
                  nd_stamp[l+1][j] = nd_stamp[l][2*j+1];
                  nd_ok[l+1][j]    = nd_ok[l][2*j+1];
                  nd_idx[l+1][j]   = nd_idx[l][2*j+1];
               end
            end
         end
      end
   end

   assign victim = hit ? hit_way : (have_free ? free_way : nd_idx[LVL][0]);

   always_comb begin
      row_new = row_rd;
      row_new[victim] = '{valid: 1'b1, tag: tag_ff, stamp: stamp_new};
   end

   // ram port control: clearing sweep or row write-back
   always_comb begin
      ram_rd_en = req_acc;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = commit && !ignored;
         ram_wr_addr = set_ff;
         ram_wr_data = row_new;
      end
   end

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (set_in),
      .rd_data (ram_rd_data)
   );

   // sequencer, counters and response register
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      clock_in     = clock_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      outcome_in   = outcome_ff;
      extra_in     = extra_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      set_cfg_in   = set_cfg_ff;
      off_cfg_in   = off_cfg_ff;
      way_cfg_in   = way_cfg_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_SET_BITS:    set_cfg_in = csr_wr_data[SET_CFG_W-1:0];
            CSR_OFFSET_BITS: off_cfg_in = csr_wr_data[OFF_CFG_W-1:0];
            CSR_WAYS_IN_USE: way_cfg_in = csr_wr_data[WAY_CFG_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + MAX_SET_BITS'(1);
            if (clr_cnt_ff == {MAX_SET_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (ignored) begin
                  outcome_in = OUT_IGNORED;
                  extra_in   = 1'b0;
               end else begin
                  extra_in  = (cmd_ff == CMD_MODIFY);
                  clock_in  = stamp_new;
                  hits_in   = sat_add(hits_ff, {1'b0, extra_in} + {1'b0, hit});
                  misses_in = sat_add(misses_ff, {1'b0, !hit});
                  evicts_in = sat_add(evicts_ff, {1'b0, !hit && !have_free});
                  if (hit) begin
                     outcome_in = OUT_HIT;
                  end else if (have_free) begin
                     outcome_in = OUT_MISS;
                  end else begin
                     outcome_in = OUT_EVICT;
                  end
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         set_cfg_ff   <= SET_CFG_RESET;
         off_cfg_ff   <= OFF_CFG_RESET;
         way_cfg_ff   <= WAY_CFG_RESET;
         clock_ff     <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         set_cfg_ff   <= set_cfg_in;
         off_cfg_ff   <= off_cfg_in;
         way_cfg_ff   <= way_cfg_in;
         clock_ff     <= clock_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      tag_ff     <= tag_in;
      set_ff     <= set_in;
      outcome_ff <= outcome_in;
      extra_ff   <= extra_in;
   end

   // totals ride with the response: they only move on commit
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.outcome          = outcome_ff;
   assign rsp_chan.modify_extra_hit = extra_ff;
   assign rsp_chan.hits_total       = hits_ff;
   assign rsp_chan.misses_total     = misses_ff;
   assign rsp_chan.evictions_total  = evicts_ff;

endmodule
